@@ design/u8s_pkg.sv @@
// Shared types and constants for the UTF-8 sequence scrubber.
`timescale 1ns / 1ps
`default_nettype none

package u8s_pkg;

  localparam int HOLD_DEPTH = 4;
  localparam int COUNT_W    = 3;
  localparam int RUN_W      = 2;

  localparam int LIMIT_RESET_VALUE = 65535;

  // register index on the config port (byte address / 4)
  localparam logic REG_OUTPUT_LIMIT = 1'b0;

  // byte classes and second-byte bounds
  localparam logic [7:0] ASCII_END  = 8'h80;
  localparam logic [7:0] LEAD2_LO   = 8'hC2;
  localparam logic [7:0] LEAD2_HI   = 8'hDF;
  localparam logic [7:0] LEAD3_LO   = 8'hE0;
  localparam logic [7:0] LEAD3_SURR = 8'hED;
  localparam logic [7:0] LEAD4_LO   = 8'hF0;
  localparam logic [7:0] LEAD4_HI   = 8'hF4;
  localparam logic [7:0] CONT_MASK  = 8'hC0;
  localparam logic [7:0] CONT_TAG   = 8'h80;
  localparam logic [7:0] E0_MIN     = 8'hA0;
  localparam logic [7:0] ED_MAX     = 8'h9F;
  localparam logic [7:0] F0_MIN     = 8'h90;
  localparam logic [7:0] F4_MAX     = 8'h8F;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_t;

  // what to do with the byte at the front of the hold buffer
  typedef enum logic [1:0] {
    ACT_DONE,   // buffer empty
    ACT_EMIT,   // front byte starts a good sequence (or is ASCII)
    ACT_DROP,   // front byte is a bad lead or an orphan, or its sequence fails a check
    ACT_SHORT   // lead waits for more bytes
  } act_t;

  typedef struct packed {
    act_t             act;
    logic [RUN_W-1:0] run;   // bytes still to follow the front in its sequence
  } verdict_t;

endpackage

`default_nettype wire

@@ design/u8s_check.sv @@
// Front-of-buffer classifier: sequence length, continuation and bound checks.
`timescale 1ns / 1ps
`default_nettype none

module u8s_check (
  input  logic [7:0]                   held [u8s_pkg::HOLD_DEPTH],
  input  logic [u8s_pkg::COUNT_W-1:0]  count,
  output u8s_pkg::verdict_t            verdict
);
  import u8s_pkg::*;

  logic [7:0]         b0;
  logic [7:0]         b1;
  logic [COUNT_W-1:0] need;
  logic               cont_ok;
  logic               bound_ok;

  assign b0 = held[0];
  assign b1 = held[1];

  always_comb begin
    if (b0 >= LEAD2_LO && b0 <= LEAD2_HI) begin
      need = COUNT_W'(2);
    end else if (b0 >= LEAD3_LO && b0 < LEAD4_LO) begin
      need = COUNT_W'(3);
    end else if (b0 >= LEAD4_LO && b0 <= LEAD4_HI) begin
      need = COUNT_W'(4);
    end else begin
      need = '0;
    end
  end

  always_comb begin
    cont_ok = 1'b1;
    for (int k = 1; k < HOLD_DEPTH; k++) begin
      if (COUNT_W'(k) < need && (held[k] & CONT_MASK) != CONT_TAG) begin
        cont_ok = 1'b0;
      end
    end
  end

  assign bound_ok = !((b0 == LEAD3_LO   && b1 < E0_MIN) ||
                      (b0 == LEAD3_SURR && b1 > ED_MAX) ||
                      (b0 == LEAD4_LO   && b1 < F0_MIN) ||
                      (b0 == LEAD4_HI   && b1 > F4_MAX));

  always_comb begin
    verdict.run = '0;
    if (count == '0) begin
      verdict.act = ACT_DONE;
    end else if (b0 < ASCII_END) begin
      verdict.act = ACT_EMIT;
    end else if (need == '0) begin
      verdict.act = ACT_DROP;
    end else if (count < need) begin
      verdict.act = ACT_SHORT;
    end else if (!(cont_ok && bound_ok)) begin
      verdict.act = ACT_DROP;
    end else begin
      verdict.act = ACT_EMIT;
      verdict.run = RUN_W'(need - COUNT_W'(1));
    end
  end

endmodule

`default_nettype wire

@@ design/utf8_sequence_scrubber.sv @@
// UTF-8 sequence scrubber: keeps well-formed UTF-8 from a byte stream, one byte per beat.
// Each input beat is accepted in idle; the scan state then emits or drops held bytes and the
//   finish state hands out the held-back byte or a bare end marker; output stalls hold both
//   states. A new beat is taken only once the last one is through. Results leave through a
//   one-beat output register; one kept byte is held back so the final beat can carry tlast.
// Reset (rst, synchronous) empties the hold buffer, clears counters, output_limit = 65535.
`timescale 1ns / 1ps
`default_nettype none

module utf8_sequence_scrubber #(
  parameter int LIMIT_WIDTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] in_byte
  input  logic        s_tlast,     // in_last
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,     // [7:0] out_byte
  output logic        m_tuser,     // [0] out_valid
  output logic        m_tlast,     // out_last
  // config port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import u8s_pkg::*;

  // ---------------------------------------------------------------------------
  // Config register
  // ---------------------------------------------------------------------------
  logic [LIMIT_WIDTH-1:0] output_limit;
  logic                   cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready && paddr[2] == REG_OUTPUT_LIMIT;
  assign prdata    = (paddr[2] == REG_OUTPUT_LIMIT) ? 32'(output_limit) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      output_limit <= LIMIT_WIDTH'(LIMIT_RESET_VALUE);
    end else if (cfg_write) begin
      output_limit <= pwdata[LIMIT_WIDTH-1:0];
    end
  end

  // ---------------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------------
  state_t                 state;
  state_t                 state_next;

  logic [7:0]             held [HOLD_DEPTH];   // prefix of one pending sequence
  logic [COUNT_W-1:0]     held_count;
  logic [RUN_W-1:0]       run;                 // committed bytes left to emit
  logic [LIMIT_WIDTH-1:0] written_count;
  logic [LIMIT_WIDTH:0]   scan_count;          // can reach output_limit + 1
  logic                   message_ended;
  logic                   at_end;              // this beat closes the message
  logic                   last_beat;
  logic                   pend_valid;          // kept byte not yet handed out
  logic [7:0]             pend_byte;

  verdict_t               verdict;

  u8s_check u_check (
    .held    (held),
    .count   (held_count),
    .verdict (verdict)
  );

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  logic accept;
  logic cut;
  logic append;
  logic out_free;
  logic front_emit;
  logic emit_write;
  logic stall;
  logic shift;
  logic step_done;
  logic finish_go;
  logic load_out;

  assign accept   = s_tvalid && s_tready;
  assign cut      = scan_count > {1'b0, output_limit};
  assign append   = accept && !message_ended && s_tdata != 8'h00 && !cut &&
                    held_count < COUNT_W'(HOLD_DEPTH);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if (step_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (finish_go) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready   = 1'b0;
    front_emit = 1'b0;
    emit_write = 1'b0;
    stall      = 1'b0;
    shift      = 1'b0;
    step_done  = 1'b0;
    finish_go  = 1'b0;
    load_out   = 1'b0;
    case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
      end
      ST_SCAN: begin
        front_emit = (run != '0) || verdict.act == ACT_EMIT;
        emit_write = front_emit && written_count < output_limit;
        // a second kept byte pushes the held-back one out
        stall      = emit_write && pend_valid && !out_free;
        shift      = (front_emit || (run == '0 && verdict.act == ACT_DROP)) && !stall;
        step_done  = run == '0 && (verdict.act == ACT_DONE || verdict.act == ACT_SHORT);
        load_out   = emit_write && pend_valid && !stall;
      end
      ST_FINISH: begin
        finish_go = !(last_beat || pend_valid) || out_free;
        load_out  = (last_beat || pend_valid) && out_free;
      end
      default: begin
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // hold buffer: append at the tail, shift one byte off the front per scan cycle unless stalled
  always_ff @(posedge clk) begin
    if (append) begin
      held[held_count[RUN_W-1:0]] <= s_tdata;
    end else if (shift) begin
      for (int i = 0; i < HOLD_DEPTH - 1; i++) begin
        held[i] <= held[i + 1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count    <= '0;
      run           <= '0;
      written_count <= '0;
      scan_count    <= '0;
      message_ended <= 1'b0;
      at_end        <= 1'b0;
      last_beat     <= 1'b0;
      pend_valid    <= 1'b0;
    end else begin
      if (accept) begin
        last_beat <= s_tlast;
        at_end    <= s_tdata == 8'h00 || cut || s_tlast;
      end
      if (append) begin
        held_count <= held_count + COUNT_W'(1);
        scan_count <= scan_count + (LIMIT_WIDTH + 1)'(1);
      end
      if (shift) begin
        held_count <= held_count - COUNT_W'(1);
        if (run != '0) begin
          run <= run - RUN_W'(1);
        end else if (verdict.act == ACT_EMIT) begin
          run <= verdict.run;
        end
      end
      if (shift && emit_write) begin
        pend_valid    <= 1'b1;
        written_count <= written_count + LIMIT_WIDTH'(1);
      end
      // incomplete lead at the end of a message: drop it and the rest
      if (step_done && at_end) begin
        held_count    <= '0;
        message_ended <= 1'b1;
      end
      if (state == ST_FINISH && finish_go) begin
        pend_valid <= 1'b0;
        if (last_beat) begin
          held_count    <= '0;
          written_count <= '0;
          scan_count    <= '0;
          message_ended <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (shift && emit_write) begin
      pend_byte <= held[0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      m_tdata <= pend_valid ? pend_byte : 8'h00;   // bare end marker carries zero
      m_tuser <= pend_valid;
      m_tlast <= state == ST_FINISH && last_beat;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
`ifndef SYNTHESIS
  // a held-back byte never survives past the end of its beat
  a_pend_flushed: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !pend_valid)
    else $error("held-back byte left over when taking a new beat");

  // held bytes never exceed the hold buffer depth
  a_hold_bound: assert property (@(posedge clk) disable iff (rst)
    held_count <= COUNT_W'(HOLD_DEPTH))
    else $error("hold buffer overflow");

  // a committed sequence is fully emitted inside the scan phase
  a_run_in_scan: assert property (@(posedge clk) disable iff (rst)
    state != ST_SCAN |-> run == '0)
    else $error("committed sequence cut short");

  // the output register is never overwritten while it still waits
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    load_out |-> out_free)
    else $error("output beat overwritten");
`endif

endmodule

`default_nettype wire

@@ bench/tb_utf8_sequence_scrubber.sv @@
// Self-checking testbench for the UTF-8 sequence scrubber stream block.
`timescale 1ns / 1ps

module tb_utf8_sequence_scrubber;
  import u8s_pkg::*;

  // bench timing and sizes
  localparam int unsigned CLK_HALF      = 6;
  localparam int unsigned RESET_CYCLES  = 4;
  localparam int unsigned IDLE_SETTLE   = 16;
  localparam int unsigned END_SETTLE    = 20;
  localparam int unsigned LONG_HOLD     = 160;     // receiver hold-off, in cycles
  localparam int unsigned HOLD_MSG_LEN  = 16;
  localparam int unsigned PHASE_BEATS   = 6;
  localparam int unsigned DRAIN_BOUND   = 20000;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned MAX_PRINTS    = 40;
  localparam int unsigned MAX_RESULTS   = 4;       // most output beats one input beat can cause

  localparam logic [7:0]  ASCII_LO  = 8'h01;
  localparam logic [7:0]  ASCII_HI  = 8'h7F;
  localparam logic [7:0]  CONT_HI   = 8'hBF;
  localparam logic [7:0]  LEAD3_HI  = 8'hEF;
  localparam logic [7:0]  BYTE_MAX  = 8'hFF;
  localparam logic [7:0]  NUL_BYTE  = 8'h00;
  localparam logic [15:0] LIMIT_MAX = 16'hFFFF;

  // one output beat: kept byte, byte-present flag, end of message
  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
  } scrub_beat_t;

  // Predicts the scrubbed stream and checks the output beats against it.
  class utf8_scrub_scoreboard;
    logic [7:0]  held [HOLD_DEPTH];
    int unsigned held_n;
    int unsigned written_n;
    int unsigned scanned_n;
    bit          msg_done;
    int unsigned limit;
    int unsigned step_n;
    scrub_beat_t kept_q[$];
    int unsigned failures;
    int unsigned beats_in;
    int unsigned beats_out;
    int unsigned messages;

    function new();
      limit     = LIMIT_RESET_VALUE;
      failures  = 0;
      beats_in  = 0;
      beats_out = 0;
      messages  = 0;
      clear_message();
    endfunction

    function void clear_message();
      held_n    = 0;
      written_n = 0;
      scanned_n = 0;
      msg_done  = 1'b0;
    endfunction

    function void keep(logic [7:0] b);
      if (written_n >= limit || step_n >= MAX_RESULTS) return;
      kept_q.push_back('{b, 1'b1, 1'b0});
      step_n++;
      written_n++;
    endfunction

    function void drop_front(int unsigned k);
      int unsigned i;
      if (k >= held_n) begin
        held_n = 0;
        return;
      end
      for (i = 0; i + k < held_n; i++) held[i] = held[i + k];
      held_n -= k;
    endfunction

    function int unsigned seq_len(logic [7:0] b);
      if (b >= LEAD2_LO && b <= LEAD2_HI) return 2;
      if (b >= LEAD3_LO && b <= LEAD3_HI) return 3;
      if (b >= LEAD4_LO && b <= LEAD4_HI) return 4;
      return 0;
    endfunction

    function bit seq_good(int unsigned need);
      int unsigned k;
      for (k = 1; k < need; k++)
        if ((held[k] & CONT_MASK) != CONT_TAG) return 1'b0;
      if (held[0] == LEAD3_LO   && held[1] <  E0_MIN) return 1'b0;
      if (held[0] == LEAD3_SURR && held[1] >  ED_MAX) return 1'b0;
      if (held[0] == LEAD4_LO   && held[1] <  F0_MIN) return 1'b0;
      if (held[0] == LEAD4_HI   && held[1] >  F4_MAX) return 1'b0;
      return 1'b1;
    endfunction

    // resolve the hold buffer; a short lead at the end drops it and all after it
    function void scan(bit at_end);
      logic [7:0]  lead;
      int unsigned need;
      int unsigned k;
      while (held_n > 0) begin
        lead = held[0];
        if (lead < ASCII_END) begin
          keep(lead);
          drop_front(1);
        end else begin
          need = seq_len(lead);
          if (need == 0) begin
            drop_front(1);
          end else if (held_n < need) begin
            if (at_end) held_n = 0;
            return;
          end else if (!seq_good(need)) begin
            drop_front(1);
          end else begin
            for (k = 0; k < need; k++) keep(held[k]);
            drop_front(need);
          end
        end
      end
    endfunction

    function void end_message();
      scan(1'b1);
      msg_done = 1'b1;
    endfunction

    // accepted input beat: queue up every output beat it causes
    function void note_input(logic [7:0] b, logic last);
      scrub_beat_t tail;
      step_n = 0;
      beats_in++;
      if (!msg_done) begin
        // a zero byte or the scan cut ends the message early
        if (b == NUL_BYTE || scanned_n > limit) begin
          end_message();
        end else if (held_n < HOLD_DEPTH) begin
          held[held_n] = b;
          held_n++;
          scanned_n++;
          scan(1'b0);
        end
      end
      if (last) begin
        if (!msg_done) end_message();
        if (step_n == 0) begin
          kept_q.push_back('{NUL_BYTE, 1'b0, 1'b1});   // bare end marker
        end else begin
          tail = kept_q.pop_back();
          tail.last = 1'b1;
          kept_q.push_back(tail);
        end
        clear_message();
        messages++;
      end
    endfunction

    function void check_result(logic [7:0] d, logic v, logic l);
      scrub_beat_t want;
      beats_out++;
      if (kept_q.size() == 0) begin
        failures++;
        if (failures <= MAX_PRINTS)
          $display("%0t: unexpected output beat: expected none, got %s", $time,
                   $sformatf("data=%02h valid=%0b last=%0b", d, v, l));
        return;
      end
      want = kept_q.pop_front();
      if (want.data !== d || want.valid !== v || want.last !== l) begin
        failures++;
        if (failures <= MAX_PRINTS)
          $display("%0t: output mismatch: expected %s, got %s", $time,
                   $sformatf("data=%02h valid=%0b last=%0b", want.data, want.valid,
                             want.last),
                   $sformatf("data=%02h valid=%0b last=%0b", d, v, l));
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;    // [7:0] in_byte
  logic        s_tlast;    // in_last
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;    // [7:0] out_byte
  logic        m_tuser;    // [0] out_valid
  logic        m_tlast;    // out_last
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  utf8_scrub_scoreboard scrub;
  logic [7:0]           msg[$];            // message being built for the sender
  int unsigned          burst_left = 0;
  bit                   hold_off_req = 1'b0;
  int unsigned          cycles = 0;

  utf8_sequence_scrubber uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // watchdog: a hung handshake ends the run here
  always @(posedge clk) begin
    cycles++;
    if (cycles == CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycles);
      $display("simulation failed");
      $finish;
    end
  end

  // output monitor: values read here are the ones that stood before the edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) scrub.check_result(m_tdata, m_tuser, m_tlast);
  end

  // Receiver: phases of full rate, light and heavy stalls; a long hold-off on
  // request so the block backs up and stalls its input.
  initial begin : receiver
    int unsigned mode;
    int unsigned run_len;
    m_tready <= 1'b0;
    @(posedge clk);
    forever begin
      if (hold_off_req) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_off_req = 1'b0;
      end else begin
        mode    = $urandom_range(0, 2);
        run_len = $urandom_range(8, 40);
        repeat (run_len) begin
          case (mode)
            0:       m_tready <= 1'b1;
            1:       m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 2) == 0);
          endcase
          @(posedge clk);
        end
      end
    end
  end

  function automatic logic [7:0] pick_byte(int unsigned lo, int unsigned hi);
    return 8'($urandom_range(hi, lo));
  endfunction

  // One input beat; bursts of random length separated by random gaps.
  task automatic send_beat(input logic [7:0] b, input logic l);
    int unsigned gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap        = $urandom_range(0, 5);
      if (gap > 0) begin
        s_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= l;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    scrub.note_input(b, l);
  endtask

  task automatic wait_drained();
    int unsigned n;
    n = 0;
    while (scrub.kept_q.size() != 0 && n < DRAIN_BOUND) begin
      @(posedge clk);
      n++;
    end
  endtask

  // sender stops until every predicted beat has left the block
  task automatic quiesce();
    s_tvalid <= 1'b0;
    burst_left = 0;
    wait_drained();
  endtask

  // register writes only at a message boundary with the block drained
  task automatic write_limit(input logic [15:0] value);
    quiesce();
    repeat (IDLE_SETTLE) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_OUTPUT_LIMIT, 2'b00};
    pwdata  <= 32'(value);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    scrub.limit = value;
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic send_message();
    int unsigned i;
    for (i = 0; i < msg.size(); i++) send_beat(msg[i], (i == msg.size() - 1));
    if ($urandom_range(0, 5) == 0) quiesce();
  endtask

  task automatic add_conts(input int unsigned n);
    repeat (n) msg.push_back(pick_byte(CONT_TAG, CONT_HI));
  endtask

  // well-formed sequence, second byte kept inside the lead's bounds
  task automatic add_valid_seq(input int unsigned need);
    logic [7:0] lead;
    logic [7:0] lo2;
    logic [7:0] hi2;
    case (need)
      2:       lead = pick_byte(LEAD2_LO, LEAD2_HI);
      3:       lead = pick_byte(LEAD3_LO, LEAD3_HI);
      default: lead = pick_byte(LEAD4_LO, LEAD4_HI);
    endcase
    lo2 = CONT_TAG;
    hi2 = CONT_HI;
    if (lead == LEAD3_LO)   lo2 = E0_MIN;
    if (lead == LEAD3_SURR) hi2 = ED_MAX;
    if (lead == LEAD4_LO)   lo2 = F0_MIN;
    if (lead == LEAD4_HI)   hi2 = F4_MAX;
    msg.push_back(lead);
    msg.push_back(pick_byte(lo2, hi2));
    add_conts(need - 2);
  endtask

  // mostly good sequences, mixed with broken ones, stray bytes and rare zeros
  task automatic build_random_message();
    int unsigned units;
    int unsigned pick;
    int unsigned need;
    int unsigned at;
    msg.delete();
    units = $urandom_range(1, 8);
    repeat (units) begin
      pick = $urandom_range(0, 99);
      need = $urandom_range(2, 4);
      if (pick < 25) begin
        msg.push_back(pick_byte(ASCII_LO, ASCII_HI));
      end else if (pick < 65) begin
        add_valid_seq(need);
      end else if (pick < 75) begin
        // one continuation replaced by a non-continuation byte
        add_valid_seq(need);
        at = msg.size() - $urandom_range(1, need - 1);
        msg[at] = $urandom_range(0, 1) ? pick_byte(ASCII_LO, ASCII_HI)
                                       : pick_byte(CONT_MASK, BYTE_MAX);
      end else if (pick < 83) begin
        // sequence cut short
        add_valid_seq(need);
        repeat ($urandom_range(1, need - 1)) void'(msg.pop_back());
      end else if (pick < 91) begin
        // second byte just outside the lead's bound
        case ($urandom_range(0, 3))
          0: begin
            msg.push_back(LEAD3_LO);
            msg.push_back(pick_byte(CONT_TAG, E0_MIN - 1));
            add_conts(1);
          end
          1: begin
            msg.push_back(LEAD3_SURR);
            msg.push_back(pick_byte(ED_MAX + 1, CONT_HI));
            add_conts(1);
          end
          2: begin
            msg.push_back(LEAD4_LO);
            msg.push_back(pick_byte(CONT_TAG, F0_MIN - 1));
            add_conts(2);
          end
          default: begin
            msg.push_back(LEAD4_HI);
            msg.push_back(pick_byte(F4_MAX + 1, CONT_HI));
            add_conts(2);
          end
        endcase
      end else if (pick < 97) begin
        msg.push_back(pick_byte(ASCII_END, BYTE_MAX));
      end else begin
        msg.push_back(NUL_BYTE);
      end
    end
  endtask

  // one output_limit setting followed by random messages
  task automatic run_phase(input logic [15:0] limit_value, input bit with_hold);
    int unsigned sent;
    write_limit(limit_value);
    if (with_hold) begin
      // long clean message while the receiver holds off
      hold_off_req = 1'b1;
      msg.delete();
      while (msg.size() < HOLD_MSG_LEN) begin
        if ($urandom_range(0, 1)) msg.push_back(pick_byte(ASCII_LO, ASCII_HI));
        else add_valid_seq($urandom_range(2, 4));
      end
      send_message();
    end
    sent = 0;
    while (sent < PHASE_BEATS) begin
      build_random_message();
      sent += msg.size();
      send_message();
    end
  endtask

  initial begin : stimulus
    scrub = new();
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tlast  <= 1'b0;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    write_limit(LIMIT_MAX);

    // ASCII top and two-byte range ends, all kept
    msg = '{8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF};
    send_message();
    // three- and four-byte sequences right on their second-byte bounds
    msg = '{8'hE0, 8'hA0, 8'h80, 8'hED, 8'h9F, 8'hBF, 8'hF4, 8'h8F, 8'hBF, 8'hBF};
    send_message();
    // bounds missed by one, overlong lead, bad continuation with rescan of 41
    msg = '{8'hE0, 8'h9F, 8'hED, 8'hA0, 8'hF0, 8'h8F, 8'hF4, 8'h90,
            8'hC1, 8'hC2, 8'h41};
    send_message();
    // held lead resolved at a zero byte; the byte after it is ignored
    msg = '{8'hE2, 8'h82, 8'h00, 8'h41};
    send_message();

    // random phases across output_limit settings, extremes included
    run_phase(LIMIT_MAX, 1'b1);
    run_phase(16'(pick_byte(2, 8)), 1'b0);
    run_phase(16'd0, 1'b0);
    run_phase(16'd1, 1'b0);
    run_phase(16'($urandom_range(9, 40)), 1'b0);
    run_phase(LIMIT_MAX, 1'b0);

    quiesce();
    repeat (END_SETTLE) @(posedge clk);
    if (scrub.kept_q.size() != 0) begin
      scrub.failures += scrub.kept_q.size();
      $display("%0t: %0d expected output beats never arrived", $time, scrub.kept_q.size());
    end

    $display("covered %0d input beats in %0d messages, %0d output beats checked",
             scrub.beats_in, scrub.messages, scrub.beats_out);
    $display("output_limit 0, 1, small, mid and 65535; bursty input, stalls, long hold-off");
    if (scrub.failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
design/u8s_pkg.sv
design/u8s_check.sv
design/utf8_sequence_scrubber.sv
bench/tb_utf8_sequence_scrubber.sv
